// ===== design/tss_pkg.sv =====
// Shared types and constants for the thermal safety supervisor.
`default_nettype none
package tss_pkg;
	localparam int TEMP_W         = 15;
	localparam int PERIOD_W       = 16;
	localparam int DUTY_W         = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int TIMER_BITS_DEF = 16;

	localparam logic [DUTY_W-1:0] FULL_DUTY = 8'd255;
	localparam logic [DUTY_W-1:0] NO_DUTY   = 8'd0;

	localparam logic signed [TEMP_W-1:0] OVERHEAT_RST  = 15'sd8000;
	localparam logic signed [TEMP_W-1:0] HIGH_RST      = 15'sd5000;
	localparam logic [PERIOD_W-1:0]      CONV_RST      = 16'd750;
	localparam logic [PERIOD_W-1:0]      BLINK_RST     = 16'd500;
	localparam logic [PERIOD_W-1:0]      TIMEOUT_RST   = 16'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERHEAT = 3'd0,
		REG_HIGH     = 3'd1,
		REG_CONV     = 3'd2,
		REG_BLINK    = 3'd3,
		REG_TIMEOUT  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_LOW  = 2'd0,
		ST_HIGH = 2'd1,
		ST_OVER = 2'd2
	} status_t;

	typedef struct packed {
		logic [DUTY_W-1:0] heater_one_drive;
		logic [DUTY_W-1:0] heater_two_drive;
		logic [DUTY_W-1:0] cooler_drive;
		logic              red_led;
		logic              green_led;
		status_t           thermal_status;
		logic              sample_taken;
	} res_t;
endpackage
`default_nettype wire

// ===== design/tss_timer.sv =====
// Saturating tick counter that fires and restarts when it reaches its period.
`default_nettype none
module tss_timer #(
	parameter int TIMER_BITS = tss_pkg::TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [tss_pkg::PERIOD_W-1:0] period,
	output logic                         fire
);
	import tss_pkg::*;

	localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

	logic [TIMER_BITS-1:0] cnt_q;
	logic [TIMER_BITS-1:0] inc;
	logic [CMP_W-1:0]      inc_x;
	logic [CMP_W-1:0]      per_x;

	assign inc   = (cnt_q == {TIMER_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign inc_x = CMP_W'(inc);
	assign per_x = CMP_W'(period);
	// a saturated counter below a wide period never fires
	assign fire  = (inc_x >= per_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= fire ? '0 : inc;
		end
	end
endmodule
`default_nettype wire

// ===== design/tss_link.sv =====
// Host-silence timeout: tracks whether the host link is up or waiting.
`default_nettype none
module tss_link #(
	parameter int TIMER_BITS = tss_pkg::TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         host_message,
	input  logic [tss_pkg::PERIOD_W-1:0] timeout,
	output logic                         link_next
);
	import tss_pkg::*;

	localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

	logic [TIMER_BITS-1:0] since_q;
	logic [TIMER_BITS-1:0] inc;
	logic                  link_q;
	logic [CMP_W-1:0]      inc_x;
	logic [CMP_W-1:0]      to_x;
	logic                  expired;

	assign inc       = (since_q == {TIMER_BITS{1'b1}}) ? since_q : since_q + 1'b1;
	assign inc_x     = CMP_W'(inc);
	assign to_x      = CMP_W'(timeout);
	assign expired   = (inc_x > to_x);
	assign link_next = host_message | (link_q & ~expired);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
			link_q  <= 1'b0;
		end else if (step) begin
			since_q <= host_message ? '0 : inc;
			link_q  <= link_next;
		end
	end
endmodule
`default_nettype wire

// ===== design/tss_thermal.sv =====
// Thermal status latch, blink phase and the drive/LED result of one tick.
`default_nettype none
module tss_thermal (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              fire_conv,
	input  logic                              fire_blink,
	input  logic                              link_next,
	input  logic signed [tss_pkg::TEMP_W-1:0] t_one,
	input  logic signed [tss_pkg::TEMP_W-1:0] t_two,
	input  logic signed [tss_pkg::TEMP_W-1:0] overheat_lvl,
	input  logic signed [tss_pkg::TEMP_W-1:0] high_lvl,
	input  logic [tss_pkg::DUTY_W-1:0]        req_one,
	input  logic [tss_pkg::DUTY_W-1:0]        req_two,
	input  logic [tss_pkg::DUTY_W-1:0]        req_cool,
	output tss_pkg::res_t                     res
);
	import tss_pkg::*;

	status_t status_q;
	status_t status_next;
	logic    phase_q;
	logic    phase_next;

	assign phase_next = phase_q ^ fire_blink;

	// overheat latches: only reset clears it
	always_comb begin
		status_next = status_q;
		if (fire_conv) begin
			if (status_q == ST_OVER || t_one >= overheat_lvl || t_two >= overheat_lvl) begin
				status_next = ST_OVER;
			end else if (t_one >= high_lvl || t_two >= high_lvl) begin
				status_next = ST_HIGH;
			end else begin
				status_next = ST_LOW;
			end
		end
	end

	always_comb begin
		res.heater_one_drive = req_one;
		res.heater_two_drive = req_two;
		res.cooler_drive     = req_cool;
		res.green_led        = link_next | phase_next;
		res.thermal_status   = status_next;
		res.sample_taken     = fire_conv;
		case (status_next)
			ST_OVER: begin
				res.heater_one_drive = NO_DUTY;
				res.heater_two_drive = NO_DUTY;
				res.cooler_drive     = FULL_DUTY;
				res.red_led          = 1'b1;
			end
			ST_HIGH: res.red_led = phase_next;
			default: res.red_led = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_LOW;
			phase_q  <= 1'b1;
		end else if (step) begin
			status_q <= status_next;
			phase_q  <= phase_next;
		end
	end
endmodule
`default_nettype wire

// ===== design/thermal_safety_supervisor_unit.sv =====
// Top level of the thermal safety supervisor.
// Each request is one millisecond tick. The block takes one request per clock
// cycle while the output is not stalled. Each accepted request passes through the
// input register, then the counters, compares and the overheat latch settle in
// one pass into the result register. The result register and input register
// both advance while a result is being taken, so back-to-back ticks stream at
// one per cycle; a stalled output holds one result plus one queued request.
// Configuration writes are always ready and should only be issued while idle.
`default_nettype none
module thermal_safety_supervisor_unit #(
	parameter int TIMER_BITS = tss_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tss_pkg::TEMP_W-1:0]   heater_one_temp,
	input  logic signed [tss_pkg::TEMP_W-1:0]   heater_two_temp,
	input  logic                                host_message,
	input  logic [tss_pkg::DUTY_W-1:0]          heater_one_request,
	input  logic [tss_pkg::DUTY_W-1:0]          heater_two_request,
	input  logic [tss_pkg::DUTY_W-1:0]          cooler_request,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tss_pkg::DUTY_W-1:0]          heater_one_drive,
	output logic [tss_pkg::DUTY_W-1:0]          heater_two_drive,
	output logic [tss_pkg::DUTY_W-1:0]          cooler_drive,
	output logic                                red_led,
	output logic                                green_led,
	output logic [1:0]                          thermal_status,
	output logic                                sample_taken,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tss_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tss_pkg::*;

	logic signed [TEMP_W-1:0] overheat_q;
	logic signed [TEMP_W-1:0] high_q;
	logic [PERIOD_W-1:0]      conv_q;
	logic [PERIOD_W-1:0]      blink_q;
	logic [PERIOD_W-1:0]      timeout_q;

	logic                     valid_s1;
	logic signed [TEMP_W-1:0] t_one_s1;
	logic signed [TEMP_W-1:0] t_two_s1;
	logic                     msg_s1;
	logic [DUTY_W-1:0]        req_one_s1;
	logic [DUTY_W-1:0]        req_two_s1;
	logic [DUTY_W-1:0]        req_cool_s1;

	logic                     out_valid_q;
	res_t                     res_q;
	res_t                     res_next;

	logic                     advance;
	logic                     fire_conv;
	logic                     fire_blink;
	logic                     link_next;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overheat_q <= OVERHEAT_RST;
			high_q     <= HIGH_RST;
			conv_q     <= CONV_RST;
			blink_q    <= BLINK_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OVERHEAT: overheat_q <= cfg_data[TEMP_W-1:0];
				REG_HIGH:     high_q     <= cfg_data[TEMP_W-1:0];
				REG_CONV:     conv_q     <= cfg_data;
				REG_BLINK:    blink_q    <= cfg_data;
				REG_TIMEOUT:  timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			t_one_s1    <= heater_one_temp;
			t_two_s1    <= heater_two_temp;
			msg_s1      <= host_message;
			req_one_s1  <= heater_one_request;
			req_two_s1  <= heater_two_request;
			req_cool_s1 <= cooler_request;
		end
	end

	tss_link #(.TIMER_BITS(TIMER_BITS)) u_link (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.host_message (msg_s1),
		.timeout      (timeout_q),
		.link_next    (link_next)
	);

	tss_timer #(.TIMER_BITS(TIMER_BITS)) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.period (conv_q),
		.fire   (fire_conv)
	);

	tss_timer #(.TIMER_BITS(TIMER_BITS)) u_blink (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.period (blink_q),
		.fire   (fire_blink)
	);

	tss_thermal u_thermal (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.fire_conv    (fire_conv),
		.fire_blink   (fire_blink),
		.link_next    (link_next),
		.t_one        (t_one_s1),
		.t_two        (t_two_s1),
		.overheat_lvl (overheat_q),
		.high_lvl     (high_q),
		.req_one      (req_one_s1),
		.req_two      (req_two_s1),
		.req_cool     (req_cool_s1),
		.res          (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign heater_one_drive = res_q.heater_one_drive;
	assign heater_two_drive = res_q.heater_two_drive;
	assign cooler_drive     = res_q.cooler_drive;
	assign red_led          = res_q.red_led;
	assign green_led        = res_q.green_led;
	assign thermal_status   = res_q.thermal_status;
	assign sample_taken     = res_q.sample_taken;
endmodule
`default_nettype wire

// ===== design/tss_checker.sv =====
// Port-level checks for the thermal safety supervisor, bound to the top level.
`default_nettype none
module tss_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [tss_pkg::DUTY_W-1:0]     heater_one_drive,
	input wire logic [tss_pkg::DUTY_W-1:0]     heater_two_drive,
	input wire logic [tss_pkg::DUTY_W-1:0]     cooler_drive,
	input wire logic                           red_led,
	input wire logic [1:0]                     thermal_status
);
	import tss_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(thermal_status)
			&& $stable(heater_one_drive) && $stable(cooler_drive))
		else $error("result changed while stalled");

	a_over_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && thermal_status == ST_OVER |-> heater_one_drive == NO_DUTY
			&& heater_two_drive == NO_DUTY && cooler_drive == FULL_DUTY && red_led)
		else $error("overheat did not force the drives");

	a_over_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && thermal_status == ST_OVER |=> !out_valid || thermal_status == ST_OVER)
		else $error("overheat latch released");

	a_low_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && thermal_status == ST_LOW |-> !red_led)
		else $error("red LED lit at low temperature");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> thermal_status == ST_LOW || thermal_status == ST_HIGH
			|| thermal_status == ST_OVER)
		else $error("undefined status code");
endmodule

bind thermal_safety_supervisor_unit tss_checker u_tss_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking regression bench for the thermal safety supervisor unit.
`timescale 1ns / 100ps
module tb_top;
	import tss_pkg::*;

	localparam int TIMER_W = TIMER_BITS_DEF;
	localparam int LATENCY_PAD = 8;
	localparam int STUCK_LIMIT = 2000;
	localparam int LONG_STALL = 300;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

	typedef struct {
		logic signed [TEMP_W-1:0] heater_one_temp;
		logic signed [TEMP_W-1:0] heater_two_temp;
		logic                     host_message;
		logic [DUTY_W-1:0]        heater_one_request;
		logic [DUTY_W-1:0]        heater_two_request;
		logic [DUTY_W-1:0]        cooler_request;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [TEMP_W-1:0] heater_one_temp;
	logic signed [TEMP_W-1:0] heater_two_temp;
	logic host_message;
	logic [DUTY_W-1:0] heater_one_request;
	logic [DUTY_W-1:0] heater_two_request;
	logic [DUTY_W-1:0] cooler_request;
	logic out_valid;
	logic out_ready;
	logic [DUTY_W-1:0] heater_one_drive;
	logic [DUTY_W-1:0] heater_two_drive;
	logic [DUTY_W-1:0] cooler_drive;
	logic red_led;
	logic green_led;
	logic [1:0] thermal_status;
	logic sample_taken;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// supervisor state as the bench sees it
	logic signed [TEMP_W-1:0] lvl_overheat = OVERHEAT_RST;
	logic signed [TEMP_W-1:0] lvl_high = HIGH_RST;
	logic [PERIOD_W-1:0] conv_period = CONV_RST;
	logic [PERIOD_W-1:0] blink_period = BLINK_RST;
	logic [PERIOD_W-1:0] link_timeout = TIMEOUT_RST;
	status_t status = ST_LOW;
	logic [TIMER_W-1:0] conv_count = '0;
	logic [TIMER_W-1:0] blink_count = '0;
	logic [TIMER_W-1:0] host_silence = '0;
	logic blink_phase = 1'b1;
	logic link_up = 1'b0;

	res_t outcome_q[$];
	res_t want;
	int mismatches = 0;
	int stuck_cycles = 0;
	int ready_wait = 0;
	int long_stall_cycles = 0;
	int temp_ceiling = 16382;
	bit idle_on = 1'b0;

	thermal_safety_supervisor_unit #(
		.TIMER_BITS(TIMER_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.heater_one_temp(heater_one_temp),
		.heater_two_temp(heater_two_temp),
		.host_message(host_message),
		.heater_one_request(heater_one_request),
		.heater_two_request(heater_two_request),
		.cooler_request(cooler_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.heater_one_drive(heater_one_drive),
		.heater_two_drive(heater_two_drive),
		.cooler_drive(cooler_drive),
		.red_led(red_led),
		.green_led(green_led),
		.thermal_status(thermal_status),
		.sample_taken(sample_taken),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] cnt);
		return (cnt == {TIMER_W{1'b1}}) ? cnt : cnt + 1'b1;
	endfunction

	// one millisecond tick of the supervisor
	function automatic res_t supervise_tick(input tick_t t);
		res_t r;
		logic sampled;
		sampled = 1'b0;
		if (t.host_message) begin
			host_silence = '0;
			link_up = 1'b1;
		end else begin
			host_silence = bump(host_silence);
			if (host_silence > link_timeout)
				link_up = 1'b0;
		end
		conv_count = bump(conv_count);
		if (conv_count >= conv_period) begin
			conv_count = '0;
			sampled = 1'b1;
			if (t.heater_one_temp >= lvl_overheat || t.heater_two_temp >= lvl_overheat)
				status = ST_OVER;
			if (status != ST_OVER) begin
				if (t.heater_one_temp >= lvl_high || t.heater_two_temp >= lvl_high)
					status = ST_HIGH;
				else
					status = ST_LOW;
			end
		end
		blink_count = bump(blink_count);
		if (blink_count >= blink_period) begin
			blink_count = '0;
			blink_phase = ~blink_phase;
		end
		r.heater_one_drive = t.heater_one_request;
		r.heater_two_drive = t.heater_two_request;
		r.cooler_drive = t.cooler_request;
		case (status)
			ST_OVER: begin
				r.heater_one_drive = NO_DUTY;
				r.heater_two_drive = NO_DUTY;
				r.cooler_drive = FULL_DUTY;
				r.red_led = 1'b1;
			end
			ST_HIGH: r.red_led = blink_phase;
			default: r.red_led = 1'b0;
		endcase
		r.green_led = link_up ? 1'b1 : blink_phase;
		r.thermal_status = status;
		r.sample_taken = sampled;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_OVERHEAT: lvl_overheat = value[TEMP_W-1:0];
			REG_HIGH:     lvl_high = value[TEMP_W-1:0];
			REG_CONV:     conv_period = value;
			REG_BLINK:    blink_period = value;
			REG_TIMEOUT:  link_timeout = value;
			default: ;
		endcase
	endfunction

	function automatic logic signed [TEMP_W-1:0] rand_temp(input int lo, input int hi);
		return TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	function automatic logic [PERIOD_W-1:0] rand_period();
		return ($urandom_range(0, 9) < 7) ? PERIOD_W'($urandom_range(0, 12))
			: PERIOD_W'($urandom_range(13, 60));
	endfunction

	function automatic tick_t make_tick(input int t1, input int t2, input bit msg,
			input int r1, input int r2, input int rc);
		tick_t t;
		t.heater_one_temp = TEMP_W'(t1);
		t.heater_two_temp = TEMP_W'(t2);
		t.host_message = msg;
		t.heater_one_request = DUTY_W'(r1);
		t.heater_two_request = DUTY_W'(r2);
		t.cooler_request = DUTY_W'(rc);
		return t;
	endfunction

	// temperatures stay at or below hi; a quarter reach down to the most negative pattern
	function automatic tick_t random_tick(input int hi, input int msg_pct);
		tick_t t;
		int near_hi;
		near_hi = (hi < 12500) ? hi : 12500;
		t.heater_one_temp = ($urandom_range(0, 3) == 0) ? rand_temp(-16384, hi)
			: rand_temp(-5500, near_hi);
		t.heater_two_temp = ($urandom_range(0, 3) == 0) ? rand_temp(-16384, hi)
			: rand_temp(-5500, near_hi);
		t.host_message = ($urandom_range(0, 99) < msg_pct);
		t.heater_one_request = DUTY_W'($urandom_range(0, 255));
		t.heater_two_request = DUTY_W'($urandom_range(0, 255));
		t.cooler_request = DUTY_W'($urandom_range(0, 255));
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		int gap;
		heater_one_temp <= t.heater_one_temp;
		heater_two_temp <= t.heater_two_temp;
		host_message <= t.host_message;
		heater_one_request <= t.heater_one_request;
		heater_two_request <= t.heater_two_request;
		cooler_request <= t.cooler_request;
		if (!in_valid)
			in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		outcome_q.push_back(supervise_tick(t));
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// writes all five registers, then one write to an index that does not exist
	task automatic configure(input logic signed [TEMP_W-1:0] oh, input logic signed [TEMP_W-1:0] hi,
			input logic [PERIOD_W-1:0] conv, input logic [PERIOD_W-1:0] blink,
			input logic [PERIOD_W-1:0] tmo);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_DATA_W-1:0] val [6];
		logic [CFG_IDX_W-1:0] spare;
		settle();
		spare = REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2));
		idx[0] = REG_OVERHEAT;  val[0] = {1'($urandom_range(0, 1)), oh};
		idx[1] = REG_HIGH;      val[1] = {1'($urandom_range(0, 1)), hi};
		idx[2] = REG_CONV;      val[2] = conv;
		idx[3] = REG_BLINK;     val[3] = blink;
		idx[4] = REG_TIMEOUT;   val[4] = tmo;
		idx[5] = spare;         val[5] = CFG_DATA_W'($urandom);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 6; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			apply_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		temp_ceiling = int'(oh) - 1;
	endtask

	task automatic test_directed();
		idle_on = 1'b0;
		// sample every tick, blink every tick, link drops on the first silent tick
		configure(16383, 5000, 1, 0, 0);
		send_tick(make_tick(-16384, -16384, 1, 0, 0, 0));
		send_tick(make_tick(-5500, -5500, 0, 255, 255, 255));
		send_tick(make_tick(4999, 4999, 1, 8'h55, 8'hAA, 8'h0F));
		send_tick(make_tick(5000, -5500, 1, 8'hAA, 8'h55, 8'hF0));
		send_tick(make_tick(-5500, 5000, 0, 1, 2, 3));
		send_tick(make_tick(12500, 12500, 0, 254, 128, 127));
		send_tick(make_tick(16382, 4999, 1, 255, 0, 255));
		send_tick(make_tick(4999, 16382, 0, 0, 255, 0));
		send_tick(make_tick(0, -1, 0, 100, 100, 100));
		// lowest high level: everything reads as high; zero conversion period
		configure(16383, -16384, 0, 1, 2);
		send_tick(make_tick(-16384, -16384, 1, 7, 8, 9));
		send_tick(make_tick(-1, -16384, 0, 10, 11, 12));
		send_tick(make_tick(0, 0, 0, 13, 14, 15));
		send_tick(make_tick(-5500, -5500, 0, 16, 17, 18));
		send_tick(make_tick(12500, -16384, 0, 19, 20, 21));
		// top high level, widest blink and timeout periods: status low once sampled, no blink toggle
		configure(16383, 16383, 3, 16'hFFFF, 16'hFFFF);
		repeat (3) begin
			send_tick(make_tick(16382, 16382, 0, 255, 255, 255));
			send_tick(make_tick(-16384, 16382, 0, 0, 0, 0));
		end
	endtask

	task automatic test_random_ticks(input int count, input bit with_idle);
		logic signed [TEMP_W-1:0] oh;
		logic signed [TEMP_W-1:0] hi;
		int msg_pct;
		oh = TEMP_W'($urandom_range(8000, 16383));
		hi = rand_temp(-5500, 12500);
		configure(oh, hi, rand_period(), rand_period(), PERIOD_W'($urandom_range(0, 30)));
		msg_pct = $urandom_range(5, 50);
		idle_on = with_idle;
		repeat (count)
			send_tick(random_tick(temp_ceiling, msg_pct));
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		idle_on = 1'b0;
		long_stall_cycles = LONG_STALL;
		repeat (40)
			send_tick(random_tick(temp_ceiling, 30));
	endtask

	task automatic test_drain_pause();
		idle_on = 1'b1;
		repeat (3) begin
			repeat (20)
				send_tick(random_tick(temp_ceiling, 20));
			wait_drained();
		end
	endtask

	// last phase: once latched only reset clears the trip
	task automatic test_overheat_latch();
		idle_on = 1'b0;
		configure(12500, 5000, 1, 4, 10);
		send_tick(make_tick(12499, 12499, 1, 50, 60, 70));
		send_tick(make_tick(0, 12500, 0, 80, 90, 100));
		send_tick(make_tick(-5500, -5500, 0, 110, 120, 130));
		configure(-16384, 16383, 2, 3, 5);
		idle_on = 1'b1;
		repeat (150)
			send_tick(random_tick(16383, 25));
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		heater_one_temp <= '0;
		heater_two_temp <= '0;
		host_message <= 1'b0;
		heater_one_request <= '0;
		heater_two_request <= '0;
		cooler_request <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_ticks(140, 1'b1);
		test_random_ticks(140, 1'b0);
		test_backpressure();
		test_random_ticks(140, 1'b1);
		test_drain_pause();
		test_random_ticks(140, 1'b1);
		test_overheat_latch();
		settle();
		if (mismatches == 0)
			$display("thermal_safety_supervisor_unit regression: pass");
		else
			$display("thermal_safety_supervisor_unit regression: fail");
		$finish;
	end

	// receiver: random hold-off after each result when idle gaps are on, or a long one on demand
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_wait = 0;
		end else begin
			if (long_stall_cycles > 0) begin
				ready_wait = long_stall_cycles;
				long_stall_cycles = 0;
			end else if (out_valid && out_ready) begin
				ready_wait = idle_on ? $urandom_range(0, 15) : 0;
			end else if (ready_wait > 0) begin
				ready_wait--;
			end
			out_ready <= (ready_wait == 0);
		end
	end

	task automatic check_field(input string name, input logic [DUTY_W-1:0] exp_val,
			input logic [DUTY_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				check_field("heater_one_drive", want.heater_one_drive, heater_one_drive);
				check_field("heater_two_drive", want.heater_two_drive, heater_two_drive);
				check_field("cooler_drive", want.cooler_drive, cooler_drive);
				check_field("red_led", DUTY_W'(want.red_led), DUTY_W'(red_led));
				check_field("green_led", DUTY_W'(want.green_led), DUTY_W'(green_led));
				check_field("thermal_status", DUTY_W'(want.thermal_status),
					DUTY_W'(thermal_status));
				check_field("sample_taken", DUTY_W'(want.sample_taken), DUTY_W'(sample_taken));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("thermal_safety_supervisor_unit regression: fail");
			$finish;
		end
	end
endmodule
